// ===== rtl/gptm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gptm_pkg
// Shared widths, register indexes, cell data types and the CORDIC angle table
// for the galvo point to mirror steps converter.
// ----------------------------------------------------------------------------
package gptm_pkg;

	// Number of CORDIC rotation cells in each angle lane (16 to 32).
	localparam int CORDIC_STAGES = 24;
	localparam int TURN_TABLE_LEN = 32;

	// The root of a 64-bit radicand takes one cell per result bit.
	localparam int SQRT_STAGES = 32;
	localparam int RAD_W = 32;
	localparam int ROOT_W = 32;
	localparam int REM_W = 34;

	localparam int CORDIC_W = 44;
	localparam int ACC_W = 33;
	localparam int ATAN_W = 30;
	localparam int SHIFT_W = 5;
	localparam int OP_SHIFT = 24;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 14;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_SPACING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_TURN = 2'd2;

	localparam int STEP_W = 13;
	localparam int PROD_W = 46;

	// atan(2^-i) in units of 2^-32 turn, rounded to nearest.
	localparam logic [ATAN_W-1:0] TURN_ATAN [TURN_TABLE_LEN] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81,
		30'd41, 30'd20, 30'd10, 30'd5,
		30'd3, 30'd1, 30'd1, 30'd0
	};

	// Partial state of the digit-by-digit square root.
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sqrt_t;

	// Vector and angle accumulator of one CORDIC lane.
	typedef struct packed {
		logic signed [CORDIC_W-1:0] px;
		logic signed [CORDIC_W-1:0] py;
		logic signed [ACC_W-1:0]    acc;
	} cordic_t;

endpackage
`default_nettype wire

// ===== rtl/galvo_point_to_mirror_steps_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// galvo_point_to_mirror_steps_core
// Converts a plane point into x and y mirror positions in microsteps.
// ----------------------------------------------------------------------------
// The block accepts one point per clock cycle while the pipeline advances and
// returns one result per point in order. The point first passes a squaring
// stage, then a chain of 32 square-root cells that builds the root one bit
// per cell, then two parallel chains of CORDIC cells (one per mirror), and
// last a scaling multiply and a rounding stage. The whole pipeline advances
// as one; it holds only while a finished result waits at the output.
// Configuration writes must be made only while no point is in flight.
module galvo_point_to_mirror_steps_core
	import gptm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic signed [15:0]    x_pos,
	input  wire logic signed [15:0]    y_pos,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [STEP_W-1:0]   x_steps,
	output logic signed [STEP_W-1:0]   y_steps
);

	localparam int CORDIC_IN = SQRT_STAGES + 1;
	localparam int MULT_IDX = CORDIC_IN + CORDIC_STAGES + 1;
	localparam int PIPE_LEN = MULT_IDX + 2;

	logic [11:0] plane_distance_q;
	logic [11:0] axis_spacing_q;
	logic [13:0] steps_per_turn_q;

	logic [PIPE_LEN-1:0] vld_q;
	logic                advance;

	logic signed [15:0] x_pipe_q [SQRT_STAGES+1];
	logic signed [15:0] y_pipe_q [SQRT_STAGES+1];
	logic [23:0]        dd_s0;
	logic [30:0]        yy_s0;
	logic signed [31:0] y_sq;

	sqrt_t   sq_chain [SQRT_STAGES+1];
	cordic_t cx_chain [CORDIC_STAGES+1];
	cordic_t cy_chain [CORDIC_STAGES+1];

	logic [32:0]       denom;
	logic [ACC_W-1:0]  mag_x;
	logic [ACC_W-1:0]  mag_y;
	logic [PROD_W-1:0] prod_x_m;
	logic [PROD_W-1:0] prod_y_m;
	logic              neg_x_m;
	logic              neg_y_m;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_distance_q <= 12'd95;
			axis_spacing_q <= 12'd19;
			steps_per_turn_q <= 14'd6400;
		end else if (wr_en) begin
			case (wr_index)
				REG_PLANE_DISTANCE: plane_distance_q <= wr_data[11:0];
				REG_AXIS_SPACING:   axis_spacing_q <= wr_data[11:0];
				REG_STEPS_PER_TURN: steps_per_turn_q <= wr_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves unless a result is waiting for its transfer.
	assign advance = !out_valid || out_ready;
	assign in_ready = advance;
	assign out_valid = vld_q[PIPE_LEN-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[PIPE_LEN-2:0], in_valid};
		end
	end

	// Squares of the plane distance and of y.
	assign y_sq = y_pos * y_pos;

	always_ff @(posedge clk) begin
		if (advance) begin
			dd_s0 <= plane_distance_q * plane_distance_q;
			yy_s0 <= y_sq[30:0];
			x_pipe_q[0] <= x_pos;
			y_pipe_q[0] <= y_pos;
			for (int i = 1; i <= SQRT_STAGES; i++) begin
				x_pipe_q[i] <= x_pipe_q[i-1];
				y_pipe_q[i] <= y_pipe_q[i-1];
			end
		end
	end

	// Square-root chain over (D^2 + y^2) * 2^32.
	always_comb begin
		sq_chain[0].rem = '0;
		sq_chain[0].root = '0;
		sq_chain[0].rad = 32'(dd_s0) + 32'(yy_s0);
	end

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		gptm_sqrt_cell u_cell (
			.clk (clk),
			.en  (advance),
			.cur (sq_chain[k]),
			.nxt (sq_chain[k+1])
		);
	end

	// Load both CORDIC lanes from the finished root and the carried point.
	assign denom = 33'({axis_spacing_q, 16'b0}) + 33'(sq_chain[SQRT_STAGES].root);

	always_ff @(posedge clk) begin
		if (advance) begin
			cx_chain[0].px <= $signed(CORDIC_W'({denom, 8'b0}));
			cx_chain[0].py <= $signed(CORDIC_W'(x_pipe_q[SQRT_STAGES])) <<< OP_SHIFT;
			cx_chain[0].acc <= '0;
			cy_chain[0].px <= $signed(CORDIC_W'({plane_distance_q, 24'b0}));
			cy_chain[0].py <= $signed(CORDIC_W'(y_pipe_q[SQRT_STAGES])) <<< OP_SHIFT;
			cy_chain[0].acc <= '0;
		end
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		gptm_cordic_cell u_x (
			.clk       (clk),
			.en        (advance),
			.shift_amt (SHIFT_W'(k)),
			.atan_step (TURN_ATAN[k]),
			.cur       (cx_chain[k]),
			.nxt       (cx_chain[k+1])
		);
		gptm_cordic_cell u_y (
			.clk       (clk),
			.en        (advance),
			.shift_amt (SHIFT_W'(k)),
			.atan_step (TURN_ATAN[k]),
			.cur       (cy_chain[k]),
			.nxt       (cy_chain[k+1])
		);
	end

	// Scale the angle magnitude by the steps per turn.
	assign mag_x = cx_chain[CORDIC_STAGES].acc[ACC_W-1] ?
		ACC_W'(-cx_chain[CORDIC_STAGES].acc) : cx_chain[CORDIC_STAGES].acc;
	assign mag_y = cy_chain[CORDIC_STAGES].acc[ACC_W-1] ?
		ACC_W'(-cy_chain[CORDIC_STAGES].acc) : cy_chain[CORDIC_STAGES].acc;

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_x_m <= PROD_W'(mag_x[31:0]) * PROD_W'(steps_per_turn_q);
			prod_y_m <= PROD_W'(mag_y[31:0]) * PROD_W'(steps_per_turn_q);
			neg_x_m <= cx_chain[CORDIC_STAGES].acc[ACC_W-1];
			neg_y_m <= cy_chain[CORDIC_STAGES].acc[ACC_W-1];
		end
	end

	// Round half away from zero, apply the sign and saturate to the field.
	function automatic logic [STEP_W-1:0] round_steps(
		input logic [PROD_W-1:0] prod,
		input logic              neg
	);
		logic [PROD_W-1:0] rnd;
		logic [13:0]       q;
		logic [STEP_W-1:0] r;
		rnd = prod + PROD_W'(64'd1 << 31);
		q = rnd[PROD_W-1:32];
		if (neg) begin
			r = (q > 14'd4096) ? 13'h1000 : 13'(-q);
		end else begin
			r = (q > 14'd4095) ? 13'h0FFF : q[STEP_W-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (advance) begin
			x_steps <= $signed(round_steps(prod_x_m, neg_x_m));
			y_steps <= $signed(round_steps(prod_y_m, neg_y_m));
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gptm_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gptm_sqrt_cell
// One digit of a restoring square root: takes two radicand bits and yields
// one root bit, then hands its state to the next cell.
// ----------------------------------------------------------------------------
module gptm_sqrt_cell
	import gptm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  en,
	input  wire sqrt_t cur,
	output sqrt_t      nxt
);

	logic [REM_W-1:0] rem_shift;
	logic [REM_W-1:0] trial;
	sqrt_t            res;

	// Bring in the next radicand digit and try the next root bit.
	always_comb begin
		rem_shift = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1:RAD_W-2]};
		trial = {cur.root[ROOT_W-1:0], 2'b01};
		res.rad = {cur.rad[RAD_W-3:0], 2'b00};
		if (rem_shift >= trial) begin
			res.rem = rem_shift - trial;
			res.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			res.rem = rem_shift;
			res.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nxt <= res;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gptm_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gptm_cordic_cell
// One vectoring CORDIC rotation toward y = 0 with its angle accumulator.
// The shift and the angle step are tied off per position in the chain.
// ----------------------------------------------------------------------------
module gptm_cordic_cell
	import gptm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [SHIFT_W-1:0]  shift_amt,
	input  wire logic [ATAN_W-1:0]   atan_step,
	input  wire cordic_t             cur,
	output cordic_t                  nxt
);

	logic signed [CORDIC_W-1:0] dx;
	logic signed [CORDIC_W-1:0] dy;
	logic signed [ACC_W-1:0]    step;
	cordic_t                    res;

	// Rotate by the sign of y; a vector already on the axis stays put.
	always_comb begin
		dx = cur.py >>> shift_amt;
		dy = cur.px >>> shift_amt;
		step = $signed({{(ACC_W-ATAN_W){1'b0}}, atan_step});
		res = cur;
		if (cur.py > 0) begin
			res.px = cur.px + dx;
			res.py = cur.py - dy;
			res.acc = cur.acc + step;
		end else if (cur.py < 0) begin
			res.px = cur.px - dx;
			res.py = cur.py + dy;
			res.acc = cur.acc - step;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nxt <= res;
		end
	end

endmodule
`default_nettype wire

// ===== sim/galvo_point_to_mirror_steps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// galvo_point_to_mirror_steps_checker
// Watches the point and step channels of the galvo converter, computes the
// expected mirror steps for each point transfer and compares every result.
// ----------------------------------------------------------------------------
module galvo_point_to_mirror_steps_checker
	import gptm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic signed [15:0]    x_pos,
	input  wire logic signed [15:0]    y_pos,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic signed [STEP_W-1:0] x_steps,
	input  wire logic signed [STEP_W-1:0] y_steps,
	output int                         errors,
	output int                         pending,
	output int                         results_seen
);

	typedef struct packed {
		logic signed [STEP_W-1:0] xs;
		logic signed [STEP_W-1:0] ys;
	} mirror_steps_t;

	// atan(2^-i) in 2^-32 turn units.
	localparam longint ATAN_TURNS [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0
	};

	logic [11:0] dist_q;
	logic [11:0] spacing_q;
	logic [13:0] spt_q;
	mirror_steps_t steps_queue [$];

	function automatic longint shift_floor(longint v, int s);
		return v >>> s;
	endfunction

	// Exact floor square root, one result bit per pass.
	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Vectoring CORDIC; returns the angle of (px, py) in 2^-32 turns.
	function automatic longint mirror_angle(longint px, longint py);
		longint acc;
		longint dx;
		longint dy;
		int n;
		acc = 0;
		n = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
		for (int i = 0; i < n; i++) begin
			dx = shift_floor(py, i);
			dy = shift_floor(px, i);
			if (py > 0) begin
				px = px + dx;
				py = py - dy;
				acc = acc + ATAN_TURNS[i];
			end else if (py < 0) begin
				px = px - dx;
				py = py + dy;
				acc = acc - ATAN_TURNS[i];
			end
		end
		return acc;
	endfunction

	// Scale turns to steps, rounding halves away from zero, then saturate.
	function automatic logic signed [STEP_W-1:0] angle_to_steps(longint turns);
		longint unsigned mag;
		longint q;
		mag = (turns < 0) ? longint'(-turns) : longint'(turns);
		q = longint'((mag * longint'(spt_q) + (64'd1 << 31)) >> 32);
		if (turns < 0)
			q = -q;
		if (q < -4096)
			q = -4096;
		if (q > 4095)
			q = 4095;
		return q[STEP_W-1:0];
	endfunction

	function automatic mirror_steps_t predict_steps(longint x, longint y);
		mirror_steps_t r;
		longint d;
		longint unsigned root;
		longint denom;
		d = longint'(dist_q);
		root = isqrt((longint'(d * d + y * y)) << 32);
		denom = (longint'(spacing_q) << 16) + longint'(root);
		r.ys = angle_to_steps(mirror_angle(d << 24, y << 24));
		r.xs = angle_to_steps(mirror_angle(denom << 8, x << 24));
		return r;
	endfunction

	assign pending = steps_queue.size();

	always @(posedge clk or negedge arst_n) begin
		mirror_steps_t want;
		if (!arst_n) begin
			dist_q <= 12'd95;
			spacing_q <= 12'd19;
			spt_q <= 14'd6400;
			errors <= 0;
			results_seen <= 0;
			steps_queue.delete();
		end else begin
			// Register writes mirror the block's configuration.
			if (wr_en) begin
				case (wr_index)
					REG_PLANE_DISTANCE: dist_q <= wr_data[11:0];
					REG_AXIS_SPACING: spacing_q <= wr_data[11:0];
					REG_STEPS_PER_TURN: spt_q <= wr_data;
					default: ;
				endcase
			end
			// Point transfer: queue the expected mirror steps.
			if (in_valid && in_ready)
				steps_queue.push_back(predict_steps(longint'(x_pos), longint'(y_pos)));
			// Step transfer: compare with the oldest expectation.
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (steps_queue.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("Unexpected result x=%0d y=%0d", x_steps, y_steps);
				end else begin
					want = steps_queue.pop_front();
					if (want.xs !== x_steps || want.ys !== y_steps) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("Mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
								want.xs, want.ys, x_steps, y_steps);
					end
				end
			end
		end
	end

endmodule

// ===== sim/galvo_point_to_mirror_steps_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// galvo_point_to_mirror_steps_core_test
// Drives points and register settings into the galvo converter with random
// stalls on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module galvo_point_to_mirror_steps_core_test;
	import gptm_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = SQRT_STAGES + CORDIC_STAGES + 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] x_pos = '0;
	logic signed [15:0] y_pos = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [STEP_W-1:0] x_steps;
	logic signed [STEP_W-1:0] y_steps;
	int errors;
	int pending;
	int results_seen;
	int cycle_count = 0;
	int points_sent = 0;
	bit calm = 1'b0;

	always #4 clk = ~clk;

	galvo_point_to_mirror_steps_core uut (.*);
	galvo_point_to_mirror_steps_checker checker_i (.*);

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side stalls in random bursts, none once the run is calm.
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 16);
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic send_point(logic signed [15:0] px, logic signed [15:0] py);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		x_pos <= px;
		y_pos <= py;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		points_sent++;
		@(negedge clk);
	endtask

	task automatic settle;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly moderate coordinates, sometimes full range.
	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 8000)) - 4000);
			default: return 16'($signed($urandom_range(0, 600)) - 300);
		endcase
	endfunction

	task automatic directed_points;
		send_point(16'sd0, 16'sd0);
		send_point(16'sd32767, 16'sd0);
		send_point(-16'sd32768, 16'sd0);
		send_point(16'sd0, 16'sd32767);
		send_point(16'sd0, -16'sd32768);
		send_point(16'sd32767, 16'sd32767);
		send_point(-16'sd32768, -16'sd32768);
		send_point(16'sd95, -16'sd95);
		send_point(-16'sd1, 16'sd1);
		send_point(16'sd21845, -16'sd10923);
		send_point(-16'sd21846, 16'sd10922);
	endtask

	initial begin
		int unsigned d_set [5] = '{95, 1, 4095, 0, 300};
		int unsigned e_set [5] = '{19, 0, 4095, 7, 2000};
		int unsigned s_set [5] = '{6400, 200, 12800, 0, 16383};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed pass at reset values, then a few register settings.
		directed_points();
		for (int p = 1; p < 5; p++) begin
			settle();
			write_reg(REG_PLANE_DISTANCE, d_set[p]);
			write_reg(REG_AXIS_SPACING, e_set[p]);
			write_reg(REG_STEPS_PER_TURN, s_set[p]);
			write_reg(2'd3, $urandom);
			directed_points();
		end

		// Random phases, each with fresh random registers.
		for (int p = 0; p < 5; p++) begin
			settle();
			write_reg(REG_PLANE_DISTANCE, $urandom_range(0, 4095));
			write_reg(REG_AXIS_SPACING, $urandom_range(0, 4095));
			write_reg(REG_STEPS_PER_TURN, $urandom_range(200, 12800));
			if (p == 4)
				calm = 1'b1;
			repeat (100) send_point(rand_coord(), rand_coord());
		end

		settle();
		$display("Sent %0d points over ten register settings; %0d results checked.",
			points_sent, results_seen);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/gptm_pkg.sv
rtl/gptm_sqrt_cell.sv
rtl/gptm_cordic_cell.sv
rtl/galvo_point_to_mirror_steps_core.sv
sim/galvo_point_to_mirror_steps_checker.sv
sim/galvo_point_to_mirror_steps_core_test.sv
